@@ src/seo_pkg.sv @@
// package for the subtask execution ordering block
// holds sizes, shared types and the controller to datapath command set
// no dependencies
package seo_pkg;

	localparam int MAX_TASKS    = 32;
	localparam int MAX_SUBTASKS = 32;

	typedef logic [5:0]  id_t;
	typedef logic [4:0]  tidx_t;
	typedef logic [31:0] mask_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_GCNT,
		OP_GRP_CLR,
		OP_GRP,
		OP_MAX,
		OP_CAND,
		OP_PICK,
		OP_DEACT,
		OP_PARTA,
		OP_SPLIT,
		OP_PARTB,
		OP_PARTC,
		OP_START,
		OP_EMIT,
		OP_CLEAR
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [5:0] idx;
		logic [5:0] lvl;
		logic [5:0] pos_l;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] task_count;
		logic [5:0] highest;
		logic [5:0] maxlen;
		logic       any;
		logic       g_zero;
		logic       more;
		logic [5:0] split;
		logic       gs_next;
	} dp_sts_t;

endpackage

@@ src/seo_in_if.sv @@
// input channel: one subtask number per transaction with end marks
// depends on seo_pkg
interface seo_in_if;
	logic           valid;
	logic           ready;
	seo_pkg::id_t   subtask_id;
	logic           end_of_task;
	logic           end_of_set;

	modport source (output valid, subtask_id, end_of_task, end_of_set, input ready);
	modport sink (input valid, subtask_id, end_of_task, end_of_set, output ready);
endinterface

@@ src/seo_out_if.sv @@
// output channel: one successor row per transaction
// depends on seo_pkg
interface seo_out_if;
	logic           valid;
	logic           ready;
	seo_pkg::id_t   row_index;
	seo_pkg::mask_t successor_mask;
	logic           starts_at_once;
	logic           last_row;

	modport source (output valid, row_index, successor_mask, starts_at_once, last_row,
		input ready);
	modport sink (input valid, row_index, successor_mask, starts_at_once, last_row,
		output ready);
endinterface

@@ src/seo_dp.sv @@
// datapath: task tables, counters, partition buffer and successor rows
// executes one command per cycle from seo_ctrl; depends on seo_pkg
module seo_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  seo_pkg::dp_cmd_t cmd,
	input  seo_pkg::id_t     in_id,
	input  logic             in_eot,
	input  logic             in_eos,
	output seo_pkg::dp_sts_t sts,
	output seo_pkg::id_t     row_index,
	output seo_pkg::mask_t   successor_mask,
	output logic             starts_at_once,
	output logic             last_row
);

	seo_pkg::mask_t mem_q [seo_pkg::MAX_TASKS];
	logic [5:0]     olen_q [seo_pkg::MAX_TASKS];
	logic [5:0]     pred_q [seo_pkg::MAX_TASKS];
	seo_pkg::tidx_t perm_q [seo_pkg::MAX_TASKS];
	seo_pkg::tidx_t tmp_q [seo_pkg::MAX_TASKS];
	logic [5:0]     gcnt_q [seo_pkg::MAX_SUBTASKS];
	logic [5:0]     cnt_q [seo_pkg::MAX_SUBTASKS];
	seo_pkg::mask_t rows_q [seo_pkg::MAX_SUBTASKS];
	seo_pkg::mask_t root_q;
	logic [31:0]    active_q;
	logic [31:0]    cvec_q;
	logic [32:0]    gs_q;
	logic [32:0]    start_q;
	logic [5:0]     tc_q;
	logic [5:0]     hs_q;
	logic [5:0]     maxlen_q;
	logic           any_q;
	logic [5:0]     maxc_q;
	logic [5:0]     best_q;
	seo_pkg::mask_t mark_q;
	logic [5:0]     g_q;
	logic [5:0]     gbest_q;
	logic           keep_q;
	logic [5:0]     x_q;
	logic [5:0]     split_q;

	seo_pkg::id_t   row_index_q;
	seo_pkg::mask_t mask_q;
	logic           start_out_q;
	logic           last_q;

	seo_pkg::tidx_t ci;
	seo_pkg::tidx_t perm_rd;
	seo_pkg::tidx_t taddr;
	seo_pkg::mask_t mrd;
	logic [5:0]     olrd;
	logic [5:0]     prd;
	logic [5:0]     raddr;
	logic [5:0]     rm1;
	seo_pkg::mask_t rrd;
	logic [5:0]     gm1;
	seo_pkg::tidx_t gb;
	logic [5:0]     idm1;
	seo_pkg::mask_t lbit;
	logic           lvld;
	logic           ldup;
	seo_pkg::mask_t newm;
	seo_pkg::mask_t fvec;
	seo_pkg::mask_t hitv;

	always_comb begin
		ci      = cmd.idx[4:0];
		perm_rd = perm_q[ci];
		case (cmd.op)
			seo_pkg::OP_LOAD: taddr = tc_q[4:0];
			seo_pkg::OP_GCNT, seo_pkg::OP_CAND, seo_pkg::OP_START: taddr = ci;
			default: taddr = perm_rd;
		endcase
		mrd   = mem_q[taddr];
		olrd  = olen_q[taddr];
		prd   = pred_q[taddr];
		raddr = (cmd.op == seo_pkg::OP_EMIT) ? cmd.idx : prd;
		rm1   = raddr - 6'd1;
		rrd   = (raddr == 6'd0) ? root_q : rows_q[rm1[4:0]];
		gm1   = g_q - 6'd1;
		gb    = gm1[4:0];
		idm1  = in_id - 6'd1;
		lbit  = seo_pkg::mask_t'(1) << idm1[4:0];
		lvld  = (in_id != 6'd0) && (in_id <= 6'(seo_pkg::MAX_SUBTASKS))
			&& (tc_q < 6'(seo_pkg::MAX_TASKS));
		ldup  = mrd[idm1[4:0]];
		newm  = lvld ? (mrd | lbit) : mrd;
		for (int j = 0; j < seo_pkg::MAX_SUBTASKS; j++) begin
			fvec[j] = (cnt_q[j] == maxc_q) && (maxc_q != 6'd0);
		end
		hitv = mrd & fvec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < seo_pkg::MAX_TASKS; t++) begin
				mem_q[t]  <= '0;
				olen_q[t] <= '0;
				pred_q[t] <= '0;
				perm_q[t] <= '0;
				tmp_q[t]  <= '0;
			end
			for (int j = 0; j < seo_pkg::MAX_SUBTASKS; j++) begin
				gcnt_q[j] <= '0;
				cnt_q[j]  <= '0;
				rows_q[j] <= '0;
			end
			root_q   <= '0;
			active_q <= '0;
			cvec_q   <= '0;
			gs_q     <= '0;
			start_q  <= '0;
			tc_q     <= '0;
			hs_q     <= '0;
			maxlen_q <= '0;
			any_q    <= 1'b0;
			maxc_q   <= '0;
			best_q   <= '0;
			mark_q   <= '0;
			g_q      <= '0;
			gbest_q  <= '0;
			keep_q   <= 1'b0;
			x_q      <= '0;
			split_q  <= '0;
		end else begin
			unique case (cmd.op)
				seo_pkg::OP_NOP, seo_pkg::OP_EMIT: begin
				end
				seo_pkg::OP_LOAD: begin
					if (lvld && !ldup) begin
						mem_q[taddr]  <= newm;
						olen_q[taddr] <= olrd + 6'd1;
					end
					if (lvld && (in_id > hs_q)) begin
						hs_q <= in_id;
					end
					if ((in_eot || in_eos) && (tc_q < 6'(seo_pkg::MAX_TASKS))
						&& (newm != '0)) begin
						tc_q <= tc_q + 6'd1;
					end
				end
				seo_pkg::OP_GCNT: begin
					for (int j = 0; j < seo_pkg::MAX_SUBTASKS; j++) begin
						gcnt_q[j] <= gcnt_q[j] + 6'(mrd[j]);
					end
					if (olrd > maxlen_q) begin
						maxlen_q <= olrd;
					end
					perm_q[taddr]   <= taddr;
					active_q[taddr] <= 1'b1;
					if (cmd.idx == 6'd0) begin
						gs_q[tc_q] <= 1'b1;
					end
				end
				seo_pkg::OP_GRP_CLR: begin
					for (int j = 0; j < seo_pkg::MAX_SUBTASKS; j++) begin
						cnt_q[j] <= '0;
					end
					any_q   <= 1'b0;
					maxc_q  <= '0;
					best_q  <= '1;
					mark_q  <= '0;
					g_q     <= '0;
					gbest_q <= '0;
					keep_q  <= 1'b1;
					x_q     <= cmd.pos_l;
				end
				seo_pkg::OP_GRP: begin
					if (active_q[taddr]) begin
						any_q <= 1'b1;
						for (int j = 0; j < seo_pkg::MAX_SUBTASKS; j++) begin
							cnt_q[j] <= cnt_q[j] + 6'(mrd[j]);
						end
					end
				end
				seo_pkg::OP_MAX: begin
					if (cnt_q[ci] > maxc_q) begin
						maxc_q <= cnt_q[ci];
					end
				end
				seo_pkg::OP_CAND: begin
					if (hitv != '0) begin
						if (olrd < best_q) begin
							best_q <= olrd;
							mark_q <= hitv;
						end else if (olrd == best_q) begin
							mark_q <= mark_q | hitv;
						end
					end
				end
				seo_pkg::OP_PICK: begin
					if (mark_q[ci] && ((g_q == 6'd0) || (gcnt_q[ci] > gbest_q))) begin
						g_q     <= {1'b0, ci} + 6'd1;
						gbest_q <= gcnt_q[ci];
					end
				end
				seo_pkg::OP_DEACT: begin
					active_q[taddr] <= 1'b0;
				end
				seo_pkg::OP_PARTA: begin
					cvec_q[ci] <= mrd[gb];
					if (mrd[gb]) begin
						tmp_q[x_q[4:0]]  <= taddr;
						x_q              <= x_q + 6'd1;
						mem_q[taddr][gb] <= 1'b0;
						if (olrd == cmd.lvl) begin
							keep_q <= 1'b0;
						end
						if (prd == 6'd0) begin
							root_q[gb] <= 1'b1;
						end else begin
							rows_q[rm1[4:0]][gb] <= 1'b1;
						end
						pred_q[taddr] <= g_q;
					end
				end
				seo_pkg::OP_SPLIT: begin
					split_q  <= x_q;
					gs_q[x_q] <= 1'b1;
				end
				seo_pkg::OP_PARTB: begin
					if (!cvec_q[ci]) begin
						tmp_q[x_q[4:0]] <= perm_rd;
						x_q             <= x_q + 6'd1;
					end
				end
				seo_pkg::OP_PARTC: begin
					perm_q[ci] <= tmp_q[ci];
					if (!keep_q && (cmd.idx < split_q)) begin
						active_q[tmp_q[ci]] <= 1'b0;
					end
				end
				seo_pkg::OP_START: begin
					start_q[prd] <= 1'b1;
				end
				seo_pkg::OP_CLEAR: begin
					for (int t = 0; t < seo_pkg::MAX_TASKS; t++) begin
						mem_q[t]  <= '0;
						olen_q[t] <= '0;
						pred_q[t] <= '0;
						perm_q[t] <= '0;
						tmp_q[t]  <= '0;
					end
					for (int j = 0; j < seo_pkg::MAX_SUBTASKS; j++) begin
						gcnt_q[j] <= '0;
						cnt_q[j]  <= '0;
						rows_q[j] <= '0;
					end
					root_q   <= '0;
					active_q <= '0;
					cvec_q   <= '0;
					gs_q     <= '0;
					start_q  <= '0;
					tc_q     <= '0;
					hs_q     <= '0;
					maxlen_q <= '0;
					any_q    <= 1'b0;
					maxc_q   <= '0;
					best_q   <= '0;
					mark_q   <= '0;
					g_q      <= '0;
					gbest_q  <= '0;
					keep_q   <= 1'b0;
					x_q      <= '0;
					split_q  <= '0;
				end
			endcase
		end
	end

	// output row register, links into start subtasks dropped outside the root row
	always_ff @(posedge clk) begin
		if (cmd.op == seo_pkg::OP_EMIT) begin
			row_index_q <= cmd.idx;
			mask_q      <= (cmd.idx == 6'd0) ? rrd : (rrd & ~start_q[32:1]);
			start_out_q <= start_q[cmd.idx];
			last_q      <= (cmd.idx == hs_q);
		end
	end

	assign row_index      = row_index_q;
	assign successor_mask = mask_q;
	assign starts_at_once = start_out_q;
	assign last_row       = last_q;

	always_comb begin
		sts.task_count = tc_q;
		sts.highest    = hs_q;
		sts.maxlen     = maxlen_q;
		sts.any        = any_q;
		sts.g_zero     = (g_q == 6'd0);
		sts.more       = (active_q != '0);
		sts.split      = split_q;
		sts.gs_next    = gs_q[cmd.idx + 6'd1];
	end

endmodule

@@ src/seo_ctrl.sv @@
// controller: sequencer for load, level by level graph build and row output
// drives seo_dp through dp_cmd_t and reads dp_sts_t; depends on seo_pkg
module seo_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_eos,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output seo_pkg::dp_cmd_t cmd,
	input  seo_pkg::dp_sts_t sts
);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_GCNT  = 5'd1;
	localparam logic [4:0] S_TOP   = 5'd2;
	localparam logic [4:0] S_GRP   = 5'd3;
	localparam logic [4:0] S_GCHK  = 5'd4;
	localparam logic [4:0] S_MAX   = 5'd5;
	localparam logic [4:0] S_CAND  = 5'd6;
	localparam logic [4:0] S_PICK  = 5'd7;
	localparam logic [4:0] S_PCHK  = 5'd8;
	localparam logic [4:0] S_DEACT = 5'd9;
	localparam logic [4:0] S_PARTA = 5'd10;
	localparam logic [4:0] S_SPLIT = 5'd11;
	localparam logic [4:0] S_PARTB = 5'd12;
	localparam logic [4:0] S_PARTC = 5'd13;
	localparam logic [4:0] S_NEXT  = 5'd14;
	localparam logic [4:0] S_START = 5'd15;
	localparam logic [4:0] S_MORE  = 5'd16;
	localparam logic [4:0] S_RSCH  = 5'd17;
	localparam logic [4:0] S_EMIT  = 5'd18;
	localparam logic [4:0] S_CLR   = 5'd19;

	logic [4:0] state_q, state_d;
	logic [5:0] i_q, i_d;
	logic [5:0] l_q, l_d;
	logic [5:0] r_q, r_d;
	logic [5:0] lvl_q, lvl_d;
	logic       ov_q, ov_d;

	always_comb begin
		state_d   = state_q;
		i_d       = i_q;
		l_d       = l_q;
		r_d       = r_q;
		lvl_d     = lvl_q;
		ov_d      = ov_q && !out_ready;
		cmd.op    = seo_pkg::OP_NOP;
		cmd.idx   = i_q;
		cmd.lvl   = lvl_q;
		cmd.pos_l = l_q;
		unique case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.op = seo_pkg::OP_LOAD;
					if (in_eos) begin
						state_d = S_GCNT;
						i_d     = '0;
					end
				end
			end
			S_GCNT: begin
				if (sts.task_count == 6'd0) begin
					state_d = S_EMIT;
					i_d     = '0;
				end else begin
					cmd.op = seo_pkg::OP_GCNT;
					if (i_q == sts.task_count - 6'd1) begin
						l_d     = '0;
						r_d     = sts.task_count - 6'd1;
						lvl_d   = 6'd1;
						state_d = S_TOP;
					end else begin
						i_d = i_q + 6'd1;
					end
				end
			end
			S_TOP: begin
				if (lvl_q > sts.maxlen) begin
					state_d = S_EMIT;
					i_d     = '0;
				end else begin
					cmd.op  = seo_pkg::OP_GRP_CLR;
					i_d     = l_q;
					state_d = S_GRP;
				end
			end
			S_GRP: begin
				cmd.op = seo_pkg::OP_GRP;
				if (i_q == r_q) begin
					state_d = S_GCHK;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			S_GCHK: begin
				i_d     = '0;
				state_d = sts.any ? S_MAX : S_NEXT;
			end
			S_MAX: begin
				cmd.op = seo_pkg::OP_MAX;
				if (i_q == sts.highest - 6'd1) begin
					i_d     = '0;
					state_d = S_CAND;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			S_CAND: begin
				cmd.op = seo_pkg::OP_CAND;
				if (i_q == sts.task_count - 6'd1) begin
					i_d     = '0;
					state_d = S_PICK;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			S_PICK: begin
				cmd.op = seo_pkg::OP_PICK;
				if (i_q == sts.highest - 6'd1) begin
					state_d = S_PCHK;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			S_PCHK: begin
				i_d     = l_q;
				state_d = sts.g_zero ? S_DEACT : S_PARTA;
			end
			S_DEACT: begin
				cmd.op = seo_pkg::OP_DEACT;
				if (i_q == r_q) begin
					state_d = S_NEXT;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			S_PARTA: begin
				cmd.op = seo_pkg::OP_PARTA;
				if (i_q == r_q) begin
					state_d = S_SPLIT;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			S_SPLIT: begin
				cmd.op  = seo_pkg::OP_SPLIT;
				i_d     = l_q;
				state_d = S_PARTB;
			end
			S_PARTB: begin
				cmd.op = seo_pkg::OP_PARTB;
				if (i_q == r_q) begin
					i_d     = l_q;
					state_d = S_PARTC;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			S_PARTC: begin
				cmd.op = seo_pkg::OP_PARTC;
				if (i_q == r_q) begin
					r_d     = sts.split - 6'd1;
					state_d = S_NEXT;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			S_NEXT: begin
				if (r_q + 6'd1 == sts.task_count) begin
					i_d     = '0;
					state_d = (lvl_q == 6'd1) ? S_START : S_MORE;
				end else begin
					l_d     = r_q + 6'd1;
					r_d     = r_q + 6'd1;
					state_d = S_RSCH;
				end
			end
			S_START: begin
				cmd.op = seo_pkg::OP_START;
				if (i_q == sts.task_count - 6'd1) begin
					state_d = S_MORE;
				end else begin
					i_d = i_q + 6'd1;
				end
			end
			S_MORE: begin
				if (!sts.more) begin
					i_d     = '0;
					state_d = S_EMIT;
				end else begin
					l_d     = '0;
					r_d     = '0;
					lvl_d   = lvl_q + 6'd1;
					state_d = S_RSCH;
				end
			end
			S_RSCH: begin
				cmd.idx = r_q;
				if (sts.gs_next) begin
					state_d = S_TOP;
				end else begin
					r_d = r_q + 6'd1;
				end
			end
			S_EMIT: begin
				if (!ov_q || out_ready) begin
					cmd.op = seo_pkg::OP_EMIT;
					ov_d   = 1'b1;
					if (i_q == sts.highest) begin
						state_d = S_CLR;
					end else begin
						i_d = i_q + 6'd1;
					end
				end
			end
			S_CLR: begin
				cmd.op  = seo_pkg::OP_CLEAR;
				state_d = S_LOAD;
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			i_q     <= '0;
			l_q     <= '0;
			r_q     <= '0;
			lvl_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			l_q     <= l_d;
			r_q     <= r_d;
			lvl_q   <= lvl_d;
			ov_q    <= ov_d;
		end
	end

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = ov_q;

`ifndef SYNTH
	a_grp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GRP) |-> (i_q >= l_q && i_q <= r_q))
		else $error("group scan index outside group");
	a_eos_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_eos) |=> !in_ready)
		else $error("input still taken after end of set");
	a_top_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOP) |-> (l_q < sts.task_count))
		else $error("group start beyond task count");
	a_clr_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> out_valid)
		else $error("last row not pending at clear");
`endif

endmodule

@@ src/subtask_execution_ordering.sv @@
// top level of the subtask execution ordering block
// joins seo_ctrl and seo_dp; depends on seo_pkg, seo_in_if, seo_out_if
//
// channel     modport  payload
// task_item   sink     subtask_id, end_of_task, end_of_set
// order_row   source   row_index, successor_mask, starts_at_once, last_row
//
// loading takes one transaction per cycle; end_of_set starts the build
// build: a setup pass over all tasks, then level by level a group search and, per group,
// a count, candidate pick and partition pass over its tasks
// rows leave one per cycle from a single output register while order_row.ready is high;
// state then clears; input stalls from end_of_set to the clear; reset skips the row register
module subtask_execution_ordering (
	input  logic       clk,
	input  logic       arst_n,
	seo_in_if.sink     task_item,
	seo_out_if.source  order_row
);

	seo_pkg::dp_cmd_t cmd;
	seo_pkg::dp_sts_t sts;

	seo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (task_item.valid),
		.in_eos    (task_item.end_of_set),
		.in_ready  (task_item.ready),
		.out_valid (order_row.valid),
		.out_ready (order_row.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	seo_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.in_id          (task_item.subtask_id),
		.in_eot         (task_item.end_of_task),
		.in_eos         (task_item.end_of_set),
		.sts            (sts),
		.row_index      (order_row.row_index),
		.successor_mask (order_row.successor_mask),
		.starts_at_once (order_row.starts_at_once),
		.last_row       (order_row.last_row)
	);

endmodule

@@ tb/testbench.sv @@
// testbench for the subtask execution ordering block: loads task sets, checks every emitted row
// against an in-bench predictor of the level-by-level precedence build
// depends on seo_pkg, seo_in_if, seo_out_if and subtask_execution_ordering
module testbench;

	typedef struct {
		seo_pkg::id_t   idx;
		seo_pkg::mask_t mask;
		logic           start;
		logic           last;
	} row_t;

	typedef struct {
		seo_pkg::id_t   id;
		logic           eot;
		logic           eos;
		bit             chk;
		seo_pkg::mask_t mask0;
		logic           last0;
	} stim_t;

	logic clk = 0;
	logic arst_n = 0;
	always #5 clk = ~clk;

	seo_in_if  task_item ();
	seo_out_if order_row ();

	subtask_execution_ordering u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.task_item (task_item.sink),
		.order_row (order_row.source)
	);

	// predictor state
	logic [63:0] mem_set [0:33];
	logic [63:0] succ    [0:33];
	int          olen    [0:33];
	int          pred    [0:33];
	bit          act     [0:33];
	int          perm    [0:33];
	bit          gstart  [0:33];
	int          gorder  [0:33];
	int          lorder  [0:33];
	bit          sset    [0:33];
	int          tcnt;
	int          hsub;

	row_t emit_buf [0:33];
	row_t rows_q [$];

	int errors = 0;
	int rows_seen = 0;
	int sets_done = 0;
	int items_sent = 0;
	bit quiet = 0;
	bit hold_req = 0;
	int idle_cnt = 0;

	function automatic bit holds(logic [63:0] m, int k);
		if (k == 0 || k > 64)
			return 0;
		return m[k-1];
	endfunction

	function automatic logic [63:0] bit_of(int k);
		if (k == 0 || k > 64)
			return 64'd0;
		return 64'd1 << (k - 1);
	endfunction

	function automatic void rank_desc(input int c [0:33], input int n, output int o [0:33]);
		int i, v, k, top;
		k = 0;
		top = 0;
		for (i = 0; i <= 33; i++)
			o[i] = 0;
		for (i = 1; i <= n; i++)
			if (c[i] > top)
				top = c[i];
		for (v = top; v > 0; v--)
			for (i = 1; i <= n; i++)
				if (c[i] == v) begin
					k++;
					o[k] = i;
				end
	endfunction

	function automatic void clear_state();
		for (int i = 0; i <= 33; i++) begin
			mem_set[i] = 0; succ[i] = 0; olen[i] = 0; pred[i] = 0; act[i] = 0;
			perm[i] = 0; gstart[i] = 0; gorder[i] = 0; lorder[i] = 0; sset[i] = 0;
		end
		tcnt = 0;
		hsub = 0;
	endfunction

	function automatic void deact(int l, int r);
		for (int i = l; i <= r; i++)
			act[perm[i]] = 0;
	endfunction

	function automatic void build_order();
		int T, S, i, j, x, l, r, lvl, maxlen, nif, nl, g, hend, t;
		int cnt [0:33];
		int ff [0:33];
		int tmp [0:33];
		bit mark [0:33];
		bit any, found, keep, more;
		T = tcnt;
		S = hsub;
		maxlen = 0;
		for (i = 0; i <= 33; i++) begin
			cnt[i] = 0;
			tmp[i] = 0;
		end
		for (i = 1; i <= T; i++) begin
			for (j = 1; j <= S; j++)
				if (holds(mem_set[i], j))
					cnt[j]++;
			if (olen[i] > maxlen)
				maxlen = olen[i];
		end
		olen[0] = 0;
		rank_desc(cnt, S, gorder);
		rank_desc(olen, T, lorder);
		for (i = 1; i <= T; i++) begin
			perm[i] = i;
			act[i] = 1;
		end
		gstart[1] = 1;
		l = 1;
		r = T;
		lvl = 1;
		while (lvl <= maxlen) begin
			any = 0;
			for (i = l; i <= r; i++)
				if (act[perm[i]])
					any = 1;
			if (any) begin
				nl = 0;
				g = 0;
				found = 0;
				for (i = 0; i <= 33; i++)
					cnt[i] = 0;
				for (i = l; i <= r; i++)
					if (act[perm[i]])
						for (j = 1; j <= S; j++)
							if (holds(mem_set[perm[i]], j))
								cnt[j]++;
				rank_desc(cnt, S, ff);
				for (x = 1; x <= S; x++)
					if (cnt[ff[1]] != cnt[ff[x]])
						break;
				nif = x;
				for (i = 0; i <= 33; i++)
					mark[i] = 0;
				for (i = T; i > 0; i--) begin
					nl = olen[lorder[i]];
					if (nl != 0)
						break;
				end
				for (i = T; i > 0; i--) begin
					t = lorder[i];
					if (olen[t] != nl) begin
						if (found)
							break;
						nl = olen[t];
					end
					for (j = 1; j < nif; j++)
						if (holds(mem_set[t], ff[j])) begin
							mark[ff[j]] = 1;
							found = 1;
						end
				end
				for (j = 1; j <= S; j++)
					if (mark[gorder[j]]) begin
						g = gorder[j];
						break;
					end
				if (g == 0) begin
					deact(l, r);
				end else begin
					keep = 1;
					x = l;
					for (i = l; i <= r; i++)
						if (holds(mem_set[perm[i]], g)) begin
							tmp[x] = perm[i];
							x++;
						end
					hend = x - 1;
					gstart[x] = 1;
					for (i = l; i <= r; i++)
						if (!holds(mem_set[perm[i]], g)) begin
							tmp[x] = perm[i];
							x++;
						end
					for (i = l; i <= r; i++)
						perm[i] = tmp[i];
					r = hend;
					for (i = l; i <= r; i++) begin
						t = perm[i];
						mem_set[t] &= ~bit_of(g);
						if (olen[t] == lvl)
							keep = 0;
						succ[pred[t]] |= bit_of(g);
						pred[t] = g;
					end
					if (!keep)
						deact(l, r);
				end
			end
			l = r + 1;
			if (l > T) begin
				more = 0;
				if (lvl == 1)
					for (i = 1; i <= T; i++)
						sset[pred[i]] = 1;
				for (i = 1; i <= T; i++)
					if (act[i])
						more = 1;
				if (!more)
					break;
				l = 1;
				lvl++;
			end
			gstart[T + 1] = 1;
			for (r = l; r <= T; r++)
				if (gstart[r + 1])
					break;
		end
		for (i = 1; i <= S; i++)
			if (sset[i])
				for (j = 1; j <= S; j++)
					succ[j] &= ~bit_of(i);
	endfunction

	function automatic void close_task();
		if (tcnt < seo_pkg::MAX_TASKS && mem_set[tcnt + 1] != 0)
			tcnt++;
	endfunction

	// apply one accepted transaction to the predictor
	function automatic void predict(seo_pkg::id_t id_in, logic eot, logic eos);
		int id, t;
		id = id_in;
		if (id >= 1 && id <= seo_pkg::MAX_SUBTASKS && tcnt < seo_pkg::MAX_TASKS) begin
			t = tcnt + 1;
			if (!holds(mem_set[t], id)) begin
				mem_set[t] |= bit_of(id);
				olen[t]++;
			end
			if (id > hsub)
				hsub = id;
		end
		if (eot || eos)
			close_task();
		if (!eos)
			return;
		if (tcnt < seo_pkg::MAX_TASKS) begin
			mem_set[tcnt + 1] = 0;
			olen[tcnt + 1] = 0;
		end
		build_order();
		for (int k = 0; k <= hsub; k++) begin
			emit_buf[k].idx = seo_pkg::id_t'(k);
			emit_buf[k].mask = succ[k][31:0];
			emit_buf[k].start = sset[k];
			emit_buf[k].last = (k == hsub);
			rows_q.push_back(emit_buf[k]);
		end
		sets_done++;
		clear_state();
	endfunction

	task automatic report(string what, longint exp_v, longint got_v);
		$display("mismatch %s: expected %0h got %0h", what, exp_v, got_v);
		errors++;
	endtask

	// sender
	task automatic send(seo_pkg::id_t id, logic eot, logic eos);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			task_item.valid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		task_item.valid <= 1;
		task_item.subtask_id <= id;
		task_item.end_of_task <= eot;
		task_item.end_of_set <= eos;
		do @(posedge clk); while (!task_item.ready);
		predict(id, eot, eos);
		items_sent++;
	endtask

	task automatic send_set(int ntask, int maxid);
		int len;
		seo_pkg::id_t id;
		logic eos;
		for (int t = 0; t < ntask; t++) begin
			len = $urandom_range(1, 5);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 11) == 0)
					id = ($urandom_range(0, 1) == 0) ? 6'd0
						: seo_pkg::id_t'($urandom_range(33, 63));
				else
					id = seo_pkg::id_t'($urandom_range(1, maxid));
				eos = (t == ntask - 1) && (k == len - 1);
				if (k == len - 1)
					send(id, eos ? logic'($urandom_range(0, 1)) : 1'b1, eos);
				else
					send(id, 1'b0, 1'b0);
			end
		end
	endtask

	stim_t dir_tab [] = '{
		'{6'd0,  1'b0, 1'b1, 1, 32'h0,        1'b1},
		'{6'd63, 1'b1, 1'b1, 1, 32'h0,        1'b1},
		'{6'd5,  1'b1, 1'b1, 1, 32'h10,       1'b0},
		'{6'd1,  1'b0, 1'b0, 0, 32'h0,        1'b0},
		'{6'd32, 1'b1, 1'b0, 0, 32'h0,        1'b0},
		'{6'd1,  1'b0, 1'b0, 0, 32'h0,        1'b0},
		'{6'd1,  1'b0, 1'b0, 0, 32'h0,        1'b0},
		'{6'd2,  1'b1, 1'b0, 0, 32'h0,        1'b0},
		'{6'd0,  1'b1, 1'b0, 0, 32'h0,        1'b0},
		'{6'd7,  1'b0, 1'b1, 0, 32'h0,        1'b0},
		'{6'd3,  1'b0, 1'b0, 0, 32'h0,        1'b0},
		'{6'd4,  1'b1, 1'b0, 0, 32'h0,        1'b0},
		'{6'd3,  1'b0, 1'b0, 0, 32'h0,        1'b0},
		'{6'd4,  1'b0, 1'b0, 0, 32'h0,        1'b0},
		'{6'd6,  1'b1, 1'b0, 0, 32'h0,        1'b0},
		'{6'd40, 1'b0, 1'b0, 0, 32'h0,        1'b0},
		'{6'd6,  1'b0, 1'b0, 0, 32'h0,        1'b0},
		'{6'd3,  1'b1, 1'b1, 0, 32'h0,        1'b0}
	};

	initial begin
		clear_state();
		task_item.valid = 0;
		task_item.subtask_id = 0;
		task_item.end_of_task = 0;
		task_item.end_of_set = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			send(dir_tab[i].id, dir_tab[i].eot, dir_tab[i].eos);
			if (dir_tab[i].chk) begin
				if (emit_buf[0].mask !== dir_tab[i].mask0)
					report("directed root mask", dir_tab[i].mask0, emit_buf[0].mask);
				if (emit_buf[0].last !== dir_tab[i].last0)
					report("directed root last", dir_tab[i].last0, emit_buf[0].last);
			end
		end
		// too many tasks: 34 single-subtask tasks
		for (int t = 0; t < 34; t++)
			send(seo_pkg::id_t'($urandom_range(1, 32)), 1'b1, t == 33);
		while (items_sent < 205) begin
			if (sets_done == 8)
				hold_req = 1;
			if (sets_done == 12) begin
				task_item.valid <= 0;
				do @(posedge clk); while (rows_q.size() != 0);
			end
			if (items_sent > 170)
				quiet = 1;
			send_set($urandom_range(1, 6), ($urandom_range(0, 2) == 0) ? 32 : $urandom_range(2, 8));
		end
		task_item.valid <= 0;
		while (rows_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("loaded %0d items in %0d task sets, checked %0d ordering rows",
			items_sent, sets_done, rows_seen);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// receiver with random stalls and one long hold-off
	initial begin
		order_row.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				order_row.ready <= 0;
				repeat (300) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				order_row.ready <= 0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				order_row.ready <= 1;
			end
		end
	end

	// row checker
	always @(posedge clk) begin
		row_t e;
		if (order_row.valid && order_row.ready) begin
			rows_seen++;
			if (rows_q.size() == 0) begin
				report("unexpected row", 0, order_row.row_index);
			end else begin
				e = rows_q.pop_front();
				if (order_row.row_index !== e.idx)
					report("row_index", e.idx, order_row.row_index);
				if (order_row.successor_mask !== e.mask)
					report("successor_mask", e.mask, order_row.successor_mask);
				if (order_row.starts_at_once !== e.start)
					report("starts_at_once", e.start, order_row.starts_at_once);
				if (order_row.last_row !== e.last)
					report("last_row", e.last, order_row.last_row);
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((task_item.valid && task_item.ready) || (order_row.valid && order_row.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > 40000) begin
			$display("watchdog expired with %0d rows outstanding", rows_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

@@ filelist.f @@
src/seo_pkg.sv
src/seo_in_if.sv
src/seo_out_if.sv
src/seo_dp.sv
src/seo_ctrl.sv
src/subtask_execution_ordering.sv
tb/testbench.sv
